>>> src/gnts_pkg.sv
`default_nettype none

package gnts_pkg;

    localparam int unsigned TIME_W    = 48;
    localparam int unsigned TICK_W    = 32;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned LAT_W     = 32;
    localparam int unsigned TRIAL_W   = 32;
    localparam int unsigned KIND_W    = 3;
    localparam int unsigned MASK_W    = 17;
    localparam int unsigned CFG_W     = 32;
    localparam int unsigned NUM_TICKS = 7;

    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 96;
    localparam int unsigned M_TUSER_W = 3;

    // outcome mask bit positions
    localparam int unsigned OM_WINDOW  = 0;
    localparam int unsigned OM_EARLY   = 1;
    localparam int unsigned OM_LATE    = 2;
    localparam int unsigned OM_HIT     = 3;
    localparam int unsigned OM_MISS    = 4;
    localparam int unsigned OM_FALARM  = 5;
    localparam int unsigned OM_CREJECT = 6;
    localparam int unsigned OM_REWARD  = 7;
    localparam int unsigned OM_PUNISH  = 8;
    localparam int unsigned OM_TYPE0   = 9;

    typedef enum logic [1:0] {
        FN_TICK  = 2'd0,
        FN_RESP  = 2'd1,
        FN_START = 2'd2,
        FN_RESET = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_PRE   = 3'd1,
        PH_CUE   = 3'd2,
        PH_DELAY = 3'd3,
        PH_WIN   = 3'd4,
        PH_POST  = 3'd5,
        PH_TOUT  = 3'd6,
        PH_ITI   = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_NEW     = 3'd1,
        EV_CUE     = 3'd2,
        EV_OUTCOME = 3'd3,
        EV_DONE    = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        CFG_PRE     = 3'd0,
        CFG_CUE     = 3'd1,
        CFG_DELAY   = 3'd2,
        CFG_WINDOW  = 3'd3,
        CFG_POST    = 3'd4,
        CFG_ITI     = 3'd5,
        CFG_TIMEOUT = 3'd6,
        CFG_THRESH  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [NUM_TICKS-1:0][TICK_W-1:0] ticks;
        logic [COUNT_W-1:0]               thresh;
    } t_cfg;

    typedef struct packed {
        t_func              func;
        logic [TIME_W-1:0]  time_us;
        logic [KIND_W-1:0]  trial_kind;
        logic               auto_reward;
        logic               house_light_on;
    } t_item;

    typedef struct packed {
        t_phase              phase;
        t_event              event_kind;
        logic [MASK_W-1:0]   outcome_mask;
        logic                sync_pulse;
        logic                cue_pulse;
        logic                reward_pulse;
        logic                punish_pulse;
        logic                house_light;
        logic                status_led;
        logic [LAT_W-1:0]    latency_us;
        logic                latency_valid;
        logic [TRIAL_W-1:0]  trial_count;
    } t_result;

endpackage

`default_nettype wire

>>> src/gnts_cfg_regs.sv
`default_nettype none

module gnts_cfg_regs
    import gnts_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_addr,
    input  wire logic [CFG_W-1:0]  i_cfg_wdata,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks  <= '0;
            r_cfg.thresh <= COUNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_PRE, CFG_CUE, CFG_DELAY, CFG_WINDOW,
                CFG_POST, CFG_ITI, CFG_TIMEOUT: begin
                    r_cfg.ticks[i_cfg_addr] <= i_cfg_wdata;
                end
                CFG_THRESH: begin
                    r_cfg.thresh <= i_cfg_wdata[COUNT_W-1:0];
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> src/gnts_core.sv
`default_nettype none

module gnts_core
    import gnts_pkg::*;
#(
    parameter int unsigned TYPE_BITS = 3
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_step,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output t_result    o_res
);

    t_phase               r_phase,    n_phase;
    logic [TICK_W-1:0]    r_ticks,    n_ticks;
    logic [TIME_W-1:0]    r_cue_time, n_cue_time;
    logic [COUNT_W-1:0]   r_win_resp, n_win_resp;
    logic                 r_early,    n_early;
    logic                 r_late,     n_late;
    logic                 r_resp,     n_resp;
    logic [TRIAL_W-1:0]   r_trials,   n_trials;
    logic [TYPE_BITS-1:0] r_kind,     n_kind;
    logic                 r_auto,     n_auto;
    logic                 r_house,    n_house;
    logic [LAT_W-1:0]     r_lat,      n_lat;
    logic                 r_lat_vld,  n_lat_vld;
    logic                 r_light,    n_light;

    logic [TIME_W-1:0]    lat_diff;
    logic [COUNT_W-1:0]   resp_inc;
    t_event               ev;
    logic [MASK_W-1:0]    mask;
    logic                 sync_p, cue_p, rew_p, pun_p;

    always_comb begin
        n_phase    = r_phase;
        n_ticks    = r_ticks;
        n_cue_time = r_cue_time;
        n_win_resp = r_win_resp;
        n_early    = r_early;
        n_late     = r_late;
        n_resp     = r_resp;
        n_trials   = r_trials;
        n_kind     = r_kind;
        n_auto     = r_auto;
        n_house    = r_house;
        n_lat      = r_lat;
        n_lat_vld  = r_lat_vld;
        n_light    = r_light;
        ev         = EV_NONE;
        mask       = '0;
        sync_p     = 1'b0;
        cue_p      = 1'b0;
        rew_p      = 1'b0;
        pun_p      = 1'b0;
        lat_diff   = i_item.time_us - r_cue_time;
        resp_inc   = (r_win_resp != '1) ? r_win_resp + COUNT_W'(1) : r_win_resp;

        unique case (i_item.func)
            FN_START: begin
                n_trials   = r_trials + TRIAL_W'(1);
                n_early    = 1'b0;
                n_late     = 1'b0;
                n_resp     = 1'b0;
                n_win_resp = '0;
                n_cue_time = '0;
                n_lat      = '0;
                n_lat_vld  = 1'b0;
                n_light    = 1'b0;
                n_kind     = i_item.trial_kind[TYPE_BITS-1:0];
                n_auto     = i_item.auto_reward;
                n_house    = i_item.house_light_on;
                sync_p     = 1'b1;
                ev         = EV_NEW;
                n_phase    = PH_PRE;
                n_ticks    = i_cfg.ticks[CFG_PRE];
            end
            FN_RESET: begin
                n_phase    = PH_IDLE;
                n_ticks    = '0;
                n_early    = 1'b0;
                n_late     = 1'b0;
                n_resp     = 1'b0;
                n_win_resp = '0;
                n_light    = 1'b0;
            end
            FN_RESP: begin
                priority if (r_phase == PH_WIN) begin
                    if (r_win_resp == '0) begin
                        n_lat     = (|lat_diff[TIME_W-1:LAT_W]) ? '1 : lat_diff[LAT_W-1:0];
                        n_lat_vld = 1'b1;
                    end
                    n_win_resp = resp_inc;
                    if (resp_inc >= i_cfg.thresh) begin
                        n_resp  = 1'b1;
                        n_ticks = '0;
                    end
                end else if (r_phase == PH_PRE || r_phase == PH_CUE || r_phase == PH_DELAY) begin
                    n_early = 1'b1;
                end else if (r_phase == PH_POST) begin
                    n_late = 1'b1;
                end else begin
                    n_early = r_early;
                end
            end
            FN_TICK: begin
                if (r_phase != PH_IDLE) begin
                    if (r_ticks != '0) begin
                        n_ticks = r_ticks - TICK_W'(1);
                    end else begin
                        unique case (r_phase)
                            PH_PRE: begin
                                n_cue_time = i_item.time_us;
                                cue_p      = (i_cfg.ticks[CFG_CUE] != '0);
                                ev         = EV_CUE;
                                n_phase    = PH_CUE;
                                n_ticks    = i_cfg.ticks[CFG_CUE];
                            end
                            PH_CUE: begin
                                n_phase = PH_DELAY;
                                n_ticks = i_cfg.ticks[CFG_DELAY];
                            end
                            PH_DELAY: begin
                                n_phase = PH_WIN;
                                n_ticks = i_cfg.ticks[CFG_WINDOW];
                            end
                            PH_WIN: begin
                                n_phase = PH_POST;
                                n_ticks = i_cfg.ticks[CFG_POST];
                            end
                            PH_POST: begin
                                mask[OM_WINDOW] = 1'b1;
                                mask[5'(OM_TYPE0) + 5'(r_kind)] = 1'b1;
                                mask[OM_EARLY] = r_early;
                                mask[OM_LATE]  = r_late;
                                n_phase = PH_ITI;
                                n_ticks = i_cfg.ticks[CFG_ITI];
                                if (r_kind == '0) begin
                                    if (r_resp) begin
                                        mask[OM_HIT]    = 1'b1;
                                        mask[OM_REWARD] = r_auto;
                                        rew_p           = r_auto;
                                    end else begin
                                        mask[OM_MISS] = 1'b1;
                                    end
                                end else if (r_resp) begin
                                    mask[OM_FALARM] = 1'b1;
                                    mask[OM_PUNISH] = 1'b1;
                                    pun_p           = 1'b1;
                                    if (i_cfg.ticks[CFG_TIMEOUT] != '0) begin
                                        n_light = 1'b0;
                                        n_phase = PH_TOUT;
                                        n_ticks = i_cfg.ticks[CFG_TIMEOUT];
                                    end
                                end else begin
                                    mask[OM_CREJECT] = 1'b1;
                                end
                                ev = EV_OUTCOME;
                            end
                            PH_TOUT: begin
                                n_light = r_house;
                                n_phase = PH_ITI;
                                n_ticks = i_cfg.ticks[CFG_ITI];
                            end
                            PH_ITI, PH_IDLE: begin
                                n_phase = PH_IDLE;
                                n_ticks = '0;
                                ev      = EV_DONE;
                            end
                        endcase
                    end
                end
            end
        endcase

        o_res.phase         = n_phase;
        o_res.event_kind    = ev;
        o_res.outcome_mask  = mask;
        o_res.sync_pulse    = sync_p;
        o_res.cue_pulse     = cue_p;
        o_res.reward_pulse  = rew_p;
        o_res.punish_pulse  = pun_p;
        o_res.house_light   = n_light;
        o_res.status_led    = (n_phase != PH_IDLE);
        o_res.latency_us    = n_lat;
        o_res.latency_valid = n_lat_vld;
        o_res.trial_count   = n_trials;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_ticks    <= '0;
            r_cue_time <= '0;
            r_win_resp <= '0;
            r_early    <= 1'b0;
            r_late     <= 1'b0;
            r_resp     <= 1'b0;
            r_trials   <= '0;
            r_kind     <= '0;
            r_auto     <= 1'b0;
            r_house    <= 1'b0;
            r_lat      <= '0;
            r_lat_vld  <= 1'b0;
            r_light    <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_ticks    <= n_ticks;
            r_cue_time <= n_cue_time;
            r_win_resp <= n_win_resp;
            r_early    <= n_early;
            r_late     <= n_late;
            r_resp     <= n_resp;
            r_trials   <= n_trials;
            r_kind     <= n_kind;
            r_auto     <= n_auto;
            r_house    <= n_house;
            r_lat      <= n_lat;
            r_lat_vld  <= n_lat_vld;
            r_light    <= n_light;
        end
    end

    a_start_enters_pre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.func == FN_START) |=> (r_phase == PH_PRE && !r_light))
        else $error("start did not enter pre-window");

    a_reset_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.func == FN_RESET) |=> (r_phase == PH_IDLE && r_ticks == '0))
        else $error("reset item did not return to idle");

    a_trial_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.func == FN_START) |=> (r_trials == $past(r_trials) + TRIAL_W'(1)))
        else $error("trial count did not advance on start");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_phase) && $stable(r_ticks) && $stable(r_trials)))
        else $error("state moved without a request");

endmodule

`default_nettype wire

>>> src/go_nogo_trial_sequencer_unit.sv
// Requests pass the input register, then the result register, to m_axis.
// Throughput: one request per cycle; the input register and the result
// register advance together whenever the result register is empty or taken.
// Reset (i_rst_n low, synchronous): phase idle, counters, flags, latency and
// other core state cleared, pipeline registers empty, resp_threshold 1, ticks 0.
`default_nettype none

module go_nogo_trial_sequencer_unit
    import gnts_pkg::*;
#(
    parameter int unsigned TYPE_BITS = 3
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [2:0]            i_cfg_addr,
    input  wire logic [CFG_W-1:0]      i_cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // time_us[47:0], trial_kind[50:48], auto_reward[51], house_light_on[52]
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    // func[1:0]
    input  wire logic [S_TUSER_W-1:0]  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // phase[2:0], outcome_mask[19:3], sync_pulse[20], cue_pulse[21],
    // reward_pulse[22], punish_pulse[23], house_light[24], status_led[25],
    // latency_us[57:26], latency_valid[58], trial_count[90:59]
    output logic [M_TDATA_W-1:0]       m_axis_tdata,
    // event_kind[2:0]
    output logic [M_TUSER_W-1:0]       m_axis_tuser
);

    t_cfg    cfg;
    t_result res;
    t_item   r_in;
    t_result r_out;
    logic    r_in_vld;
    logic    r_out_vld;
    logic    adv;
    logic    step;

    gnts_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    assign adv           = !r_out_vld || m_axis_tready;
    assign step          = r_in_vld && adv;
    assign s_axis_tready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.func           <= t_func'(s_axis_tuser);
            r_in.time_us        <= s_axis_tdata[47:0];
            r_in.trial_kind     <= s_axis_tdata[50:48];
            r_in.auto_reward    <= s_axis_tdata[51];
            r_in.house_light_on <= s_axis_tdata[52];
        end
    end

    gnts_core #(
        .TYPE_BITS (TYPE_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.event_kind;
    assign m_axis_tdata  = {5'b0, r_out.trial_count, r_out.latency_valid, r_out.latency_us,
                            r_out.status_led, r_out.house_light, r_out.punish_pulse,
                            r_out.reward_pulse, r_out.cue_pulse, r_out.sync_pulse,
                            r_out.outcome_mask, r_out.phase};

endmodule

`default_nettype wire
